[hdl/wall_clock_slew_discipline_macros.svh]
// Assertion helpers for the checker file of this block.
`ifndef WALL_CLOCK_SLEW_DISCIPLINE_MACROS_SVH
`define WALL_CLOCK_SLEW_DISCIPLINE_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define WCSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define WCSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define WCSD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/wcsd_pkg.sv]
package wcsd_pkg;

  localparam int HZ_W    = 34;
  localparam int WORD_W  = 64;
  localparam int MPL_W   = 35;
  localparam int PROD_W  = WORD_W + 11;
  localparam int PPM_W   = 10;
  localparam int SRC_W   = 32;
  localparam int RTC_W   = 35;
  localparam int IN_W    = 208;
  localparam int OUT_W   = 232;

  localparam logic [WORD_W-1:0] NS_PER_S     = 64'd1000000000;
  localparam logic [WORD_W-1:0] Y2000_NS     = 64'd946684800000000000;
  localparam logic [WORD_W-1:0] STEP_LIMIT   = 64'd300000000000;
  localparam logic [WORD_W-1:0] SEC_MAX      = 64'd18446744073;
  localparam logic [WORD_W-1:0] I64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [HZ_W-1:0]   PPM_DIV      = 34'd1000000;
  localparam logic [HZ_W-1:0]   HZ_RESET     = 34'd1000000000;
  localparam logic [PPM_W-1:0]  PPM_MAX      = 10'd1000;

endpackage

[hdl/wcsd_div.sv]
module wcsd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wcsd_pkg::WORD_W-1:0]   dividend,
  input  logic [wcsd_pkg::HZ_W-1:0]     divisor,
  output logic                          done,
  output logic [wcsd_pkg::WORD_W-1:0]   quot,
  output logic [wcsd_pkg::HZ_W-1:0]     rem
);
  import wcsd_pkg::*;

  logic [WORD_W-1:0] q_r;
  logic [HZ_W-1:0]   rem_r;
  logic [HZ_W-1:0]   dsr_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [HZ_W:0]     trial;
  logic [HZ_W:0]     diff;
  logic              ge;

  // One quotient bit per cycle, dividend shifted out at the top of q_r.
  always_comb begin
    trial = {rem_r, q_r[WORD_W-1]};
    diff  = trial - {1'b0, dsr_r};
    ge    = (trial >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= {q_r[WORD_W-2:0], ge};
        rem_r <= ge ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

endmodule

[hdl/wcsd_mul.sv]
module wcsd_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wcsd_pkg::WORD_W-1:0]   mcand,
  input  logic [wcsd_pkg::MPL_W-1:0]    mplier,
  output logic                          done,
  output logic [wcsd_pkg::PROD_W-1:0]   prod
);
  import wcsd_pkg::*;

  logic [WORD_W-1:0] mcand_r;
  logic [MPL_W-1:0]  mplier_r;
  logic [PROD_W-1:0] acc_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;

  // Multiplier bits are consumed most significant first: shift, then add.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r   <= 1'b1;
        cnt_r    <= '0;
        mcand_r  <= mcand;
        mplier_r <= mplier;
        acc_r    <= '0;
      end else if (busy_r) begin
        acc_r    <= {acc_r[PROD_W-2:0], 1'b0}
                    + (mplier_r[MPL_W-1] ? {{(PROD_W-WORD_W){1'b0}}, mcand_r} : '0);
        mplier_r <= {mplier_r[MPL_W-2:0], 1'b0};
        cnt_r    <= cnt_r + 6'd1;
        if (cnt_r == 6'(MPL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[hdl/wall_clock_slew_discipline.sv]
// Channel   Dir  Contents
// in_*      in   tuser: kind; tdata: counter_ticks, ref_wall_ns, time_source, max_ppm,
//                rtc_seconds
// out_*     out  tdata: status, wall_ns, slew_left_ns, current_source, last_sync_ns
// cfg_*     in   tick_hz, written whenever cfg_wr_en is high
//
// One item is in work at a time; its result follows the tick conversion (a division, two
// products and a second division), comes sooner when the seconds part saturates or tick_hz
// is zero, and later for a calibrate or a read or discipline with a slew running. The shared
// one-bit-per-cycle divider and shift-add multiplier, up to three uses of each, do the
// arithmetic; the input reopens in the cycle after the commit.
// rst_n is synchronous and reloads tick_hz to 1 GHz; a waiting result holds the next item's commit.
module wall_clock_slew_discipline (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // counter_ticks[63:0], ref_wall_ns[127:64], time_source[159:128],
  // max_ppm[169:160], rtc_seconds[204:170], zero fill above
  input  logic [wcsd_pkg::IN_W-1:0]    in_tdata,
  // kind[1:0]
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // status[0], wall_ns[64:1], slew_left_ns[128:65], current_source[160:129],
  // last_sync_ns[224:161], zero fill above
  output logic [wcsd_pkg::OUT_W-1:0]   out_tdata,
  input  logic                         cfg_wr_en,
  input  logic [wcsd_pkg::HZ_W-1:0]    cfg_wr_data
);
  import wcsd_pkg::*;

  typedef enum logic [1:0] {KIND_READ, KIND_SET, KIND_DISC, KIND_CAL} kind_t;

  // Tick conversion runs first while tick_hz is nonzero, then the read path when the item needs
  // the current wall time or the RTC product for a calibrate, then S_APPLY commits the item.
  typedef enum logic [3:0] {
    S_IDLE, S_DIV_T, S_MUL_S, S_MUL_R, S_DIV_R, S_DISPATCH, S_MUL_RTC,
    S_WALL_BASE, S_WALL_MUL, S_WALL_DIV, S_WALL_SLEW, S_WALL_FIN, S_APPLY
  } state_t;

  state_t state_r;

  logic [HZ_W-1:0]   hz_r;
  kind_t             kind_r;
  logic [WORD_W-1:0] epoch_r;
  logic [SRC_W-1:0]  src_r;
  logic [PPM_W-1:0]  ppm_r;
  logic [RTC_W-1:0]  rtc_r;
  logic [HZ_W-1:0]   r_r;
  logic [WORD_W-1:0] p1_r;
  logic [WORD_W-1:0] now_r;
  logic [WORD_W-1:0] cand_r;
  logic [WORD_W-1:0] lim_r;
  logic [WORD_W-1:0] rtcw_r;

  // Clock state.
  logic [WORD_W-1:0] base_wall_r, base_mono_r, last_r, mark_r, pend_r, sync_mono_r;
  logic [PPM_W-1:0]  rate_r;
  logic              cal_r;
  logic [SRC_W-1:0]  sync_src_r;

  logic [WORD_W-1:0] base_wall_nxt, base_mono_nxt, last_nxt, mark_nxt, pend_nxt;
  logic [WORD_W-1:0] sync_mono_nxt;
  logic [PPM_W-1:0]  rate_nxt;
  logic              cal_nxt;
  logic [SRC_W-1:0]  sync_src_nxt;
  logic              status_nxt;
  logic [WORD_W-1:0] wall_nxt;

  logic              out_valid_r;
  logic              out_status_r;
  logic [WORD_W-1:0] out_wall_r, out_slew_r, out_sync_r;
  logic [SRC_W-1:0]  out_src_r;

  logic              div_start, div_done;
  logic [WORD_W-1:0] div_a, div_quot;
  logic [HZ_W-1:0]   div_b, div_rem;
  logic              mul_start, mul_done;
  logic [WORD_W-1:0] mul_a;
  logic [MPL_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_prod;

  logic              accept, fire;
  logic              s_sat, rtc_sat, disc_bad, slew_act;
  logic [WORD_W-1:0] elapsed, base_cand, span, mag, lim, slew_cand;
  logic [WORD_W:0]   sum_base, sum_slew;
  logic [WORD_W-1:0] diff, fin_cand;
  logic              set_ok, step, too_far;

  wcsd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  wcsd_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .mcand(mul_a), .mplier(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign fire      = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // Conditions of the read path and of the commit cycle.
  always_comb begin
    s_sat     = (div_quot > SEC_MAX);
    rtc_sat   = ({{(WORD_W-RTC_W){1'b0}}, rtc_r} > SEC_MAX);
    disc_bad  = (epoch_r < Y2000_NS) || (src_r == '0) || (ppm_r == '0) || (ppm_r > PPM_MAX);
    elapsed   = (now_r >= base_mono_r) ? (now_r - base_mono_r) : '0;
    sum_base  = {1'b0, base_wall_r} + {1'b0, elapsed};
    base_cand = sum_base[WORD_W] ? '1 : sum_base[WORD_W-1:0];
    slew_act  = (pend_r != '0) && (now_r >= mark_r);
    span      = now_r - mark_r;
    mag       = pend_r[WORD_W-1] ? (~pend_r + 64'd1) : pend_r;
    lim       = (lim_r > mag) ? mag : lim_r;
    sum_slew  = {1'b0, cand_r} + {1'b0, lim};
    if (pend_r[WORD_W-1]) begin
      slew_cand = (cand_r > lim) ? (cand_r - lim) : '0;
    end else begin
      slew_cand = sum_slew[WORD_W] ? '1 : sum_slew[WORD_W-1:0];
    end
    fin_cand  = (cand_r < last_r) ? last_r : cand_r;
    diff      = (cand_r > epoch_r) ? (cand_r - epoch_r) : (epoch_r - cand_r);
    set_ok    = !((epoch_r < Y2000_NS) || (src_r == '0) || (cal_r && (epoch_r < last_r)));
    step      = !cal_r || (cand_r < Y2000_NS) || ((epoch_r > cand_r) && (diff > STEP_LIMIT));
    too_far   = (diff > I64_MAX);
  end

  // Operand selection for the shared divider and multiplier.
  always_comb begin
    div_start = 1'b0;
    div_a     = in_tdata[WORD_W-1:0];
    div_b     = hz_r;
    mul_start = 1'b0;
    mul_a     = NS_PER_S;
    mul_b     = div_quot[MPL_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        div_start = accept && (hz_r != '0);
      end
      S_DIV_T: begin
        mul_start = div_done && !s_sat;
      end
      S_MUL_S: begin
        mul_start = mul_done;
        mul_b     = {1'b0, r_r};
      end
      S_MUL_R: begin
        div_start = mul_done;
        div_a     = mul_prod[WORD_W-1:0];
      end
      S_DISPATCH: begin
        mul_start = (kind_r == KIND_CAL) && !rtc_sat;
        mul_b     = rtc_r;
      end
      S_WALL_BASE: begin
        mul_start = slew_act;
        mul_a     = span;
        mul_b     = {{(MPL_W-PPM_W){1'b0}}, rate_r};
      end
      S_WALL_MUL: begin
        div_start = mul_done && (mul_prod[PROD_W-1:WORD_W] == '0);
        div_a     = mul_prod[WORD_W-1:0];
        div_b     = PPM_DIV;
      end
      default: begin
      end
    endcase
  end

  // What the commit cycle leaves behind, per kind of item.
  always_comb begin
    base_wall_nxt = base_wall_r;
    base_mono_nxt = base_mono_r;
    last_nxt      = last_r;
    mark_nxt      = mark_r;
    pend_nxt      = pend_r;
    rate_nxt      = rate_r;
    cal_nxt       = cal_r;
    sync_src_nxt  = sync_src_r;
    sync_mono_nxt = sync_mono_r;
    status_nxt    = 1'b0;
    case (kind_r) inside
      KIND_READ: begin
      end
      KIND_SET, KIND_DISC: begin
        if ((kind_r == KIND_DISC) && disc_bad) begin
          status_nxt = 1'b1;
        end else if ((kind_r == KIND_SET) || step) begin
          if (set_ok) begin
            base_wall_nxt = epoch_r;
            base_mono_nxt = now_r;
            last_nxt      = epoch_r;
            mark_nxt      = now_r;
            pend_nxt      = '0;
            rate_nxt      = '0;
            cal_nxt       = 1'b1;
            sync_src_nxt  = src_r;
            sync_mono_nxt = now_r;
          end else begin
            status_nxt = 1'b1;
          end
        end else if (too_far) begin
          status_nxt = 1'b1;
        end else begin
          // Small offset: start a slew toward the reference.
          pend_nxt      = (cand_r > epoch_r) ? (~diff + 64'd1) : diff;
          rate_nxt      = ppm_r;
          mark_nxt      = now_r;
          sync_src_nxt  = src_r;
          sync_mono_nxt = now_r;
        end
      end
      default: begin
        // Calibrate keeps any slew in progress.
        base_wall_nxt = rtcw_r;
        base_mono_nxt = now_r;
        last_nxt      = rtcw_r;
        mark_nxt      = now_r;
        cal_nxt       = 1'b1;
        sync_src_nxt  = {{(SRC_W-1){1'b0}}, 1'b1};
        sync_mono_nxt = now_r;
      end
    endcase
    wall_nxt = (kind_r == KIND_READ) ? cand_r : last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hz_r        <= HZ_RESET;
      out_valid_r <= 1'b0;
      base_wall_r <= '0;
      base_mono_r <= '0;
      last_r      <= '0;
      mark_r      <= '0;
      pend_r      <= '0;
      rate_r      <= '0;
      cal_r       <= 1'b0;
      sync_src_r  <= '0;
      sync_mono_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        hz_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && !fire) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kind_r  <= kind_t'(in_tuser);
            epoch_r <= in_tdata[127:64];
            src_r   <= in_tdata[159:128];
            ppm_r   <= in_tdata[169:160];
            rtc_r   <= in_tdata[204:170];
            if (hz_r == '0) begin
              now_r   <= '0;
              state_r <= S_DISPATCH;
            end else begin
              state_r <= S_DIV_T;
            end
          end
        end
        S_DIV_T: begin
          if (div_done) begin
            r_r <= div_rem;
            if (s_sat) begin
              now_r   <= '1;
              state_r <= S_DISPATCH;
            end else begin
              state_r <= S_MUL_S;
            end
          end
        end
        S_MUL_S: begin
          if (mul_done) begin
            p1_r    <= mul_prod[WORD_W-1:0];
            state_r <= S_MUL_R;
          end
        end
        S_MUL_R: begin
          if (mul_done) begin
            state_r <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            now_r   <= p1_r + div_quot;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          cand_r <= now_r;
          case (kind_r)
            KIND_READ: begin
              state_r <= cal_r ? S_WALL_BASE : S_APPLY;
            end
            KIND_DISC: begin
              state_r <= (cal_r && !disc_bad) ? S_WALL_BASE : S_APPLY;
            end
            KIND_CAL: begin
              if (rtc_sat) begin
                rtcw_r  <= '1;
                state_r <= S_APPLY;
              end else begin
                state_r <= S_MUL_RTC;
              end
            end
            default: begin
              state_r <= S_APPLY;
            end
          endcase
        end
        S_MUL_RTC: begin
          if (mul_done) begin
            rtcw_r  <= mul_prod[WORD_W-1:0];
            state_r <= S_APPLY;
          end
        end
        S_WALL_BASE: begin
          cand_r  <= base_cand;
          state_r <= slew_act ? S_WALL_MUL : S_WALL_FIN;
        end
        S_WALL_MUL: begin
          if (mul_done) begin
            if (mul_prod[PROD_W-1:WORD_W] != '0) begin
              lim_r   <= '1;
              state_r <= S_WALL_SLEW;
            end else begin
              state_r <= S_WALL_DIV;
            end
          end
        end
        S_WALL_DIV: begin
          if (div_done) begin
            lim_r   <= div_quot;
            state_r <= S_WALL_SLEW;
          end
        end
        S_WALL_SLEW: begin
          cand_r  <= slew_cand;
          pend_r  <= pend_r[WORD_W-1] ? (pend_r + lim) : (pend_r - lim);
          mark_r  <= now_r;
          state_r <= S_WALL_FIN;
        end
        S_WALL_FIN: begin
          // Never return less than what was last returned.
          cand_r      <= fin_cand;
          base_wall_r <= fin_cand;
          base_mono_r <= now_r;
          last_r      <= fin_cand;
          state_r     <= S_APPLY;
        end
        S_APPLY: begin
          if (fire) begin
            base_wall_r  <= base_wall_nxt;
            base_mono_r  <= base_mono_nxt;
            last_r       <= last_nxt;
            mark_r       <= mark_nxt;
            pend_r       <= pend_nxt;
            rate_r       <= rate_nxt;
            cal_r        <= cal_nxt;
            sync_src_r   <= sync_src_nxt;
            sync_mono_r  <= sync_mono_nxt;
            out_valid_r  <= 1'b1;
            out_status_r <= status_nxt;
            out_wall_r   <= wall_nxt;
            out_slew_r   <= pend_nxt;
            out_src_r    <= sync_src_nxt;
            out_sync_r   <= sync_mono_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_sync_r, out_src_r, out_slew_r, out_wall_r, out_status_r};

endmodule

[hdl/wcsd_checker.sv]
`include "wall_clock_slew_discipline_macros.svh"

module wcsd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [wcsd_pkg::OUT_W-1:0]  out_tdata
);

  // A stalled result keeps its contents.
  `WCSD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // Only one item is in work: the input closes right after a transfer.
  `WCSD_ASSERT_NEXT(a_one_item, clk, rst_n, in_tvalid && in_tready, !in_tready, "input open while an item is in work")

  // Reset leaves no result pending.
  `WCSD_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n, !out_tvalid, "result pending after reset")

  // The fill bits above the last field stay zero.
  `WCSD_ASSERT_NOW(a_out_fill, clk, rst_n, out_tvalid, out_tdata[231:225] == 7'd0, "fill bits set")

endmodule

bind wall_clock_slew_discipline wcsd_checker u_wcsd_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
